@@ rtl/hid_report_to_ps2_make_codes_defines.svh @@
// Assertion helpers shared by the RTL.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef HID_REPORT_TO_PS2_MAKE_CODES_DEFINES_SVH
`define HID_REPORT_TO_PS2_MAKE_CODES_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRPS2_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRPS2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hrps2_pkg.sv @@
`timescale 1ns / 1ps

package hrps2_pkg;

  localparam int MAX_SLOTS = 6;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);

  localparam logic [7:0] SHIFT_MASK   = 8'h22;  // left shift (bit 1) and right shift (bit 5)
  localparam logic [7:0] SHIFT_MAKE   = 8'h12;
  localparam logic [7:0] BREAK_PREFIX = 8'hF0;

  // queue depths, both powers of two
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  typedef enum logic {
    CMD_REPORT   = 1'b0,
    CMD_TABLE_WR = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_MAKE  = 2'd1,
    SH_BREAK = 2'd2
  } shift_ev_t;

  typedef logic [7:0] byte_t;

  // classified request, front to back
  typedef struct packed {
    cmd_kind_t                   kind;
    shift_ev_t                   shift_ev;
    logic [MAX_SLOTS-1:0]        new_mask;
    logic [MAX_SLOTS-1:0][7:0]   keys;
    byte_t                       tbl_index;
    byte_t                       tbl_code;
  } cmd_t;

  typedef struct packed {
    byte_t scan_byte;
    logic  last;
  } out_item_t;

endpackage

@@ rtl/hrps2_fifo.sv @@
`timescale 1ns / 1ps

module hrps2_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/hrps2_front.sv @@
`timescale 1ns / 1ps

module hrps2_front #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      accept_i,
  input  logic                                      action_i,
  input  logic [7:0]                                modifier_i,
  input  logic [hrps2_pkg::MAX_SLOTS-1:0][7:0]      keys_i,
  input  logic [7:0]                                table_index_i,
  input  logic [7:0]                                table_code_i,
  output hrps2_pkg::cmd_t                           cmd_o
);

  logic [7:0] prev_keys_r [hrps2_pkg::MAX_SLOTS];
  logic       prev_shift_r;
  logic       shift;
  logic [hrps2_pkg::MAX_SLOTS-1:0] new_mask;

  assign shift = |(modifier_i & hrps2_pkg::SHIFT_MASK);

  // a key is new when nonzero and absent from the previous report's active slots
  always_comb begin
    logic seen;
    new_mask = '0;
    for (int i = 0; i < hrps2_pkg::MAX_SLOTS; i++) begin
      seen = 1'b0;
      for (int j = 0; j < hrps2_pkg::MAX_SLOTS; j++) begin
        if (j < KEY_SLOTS && prev_keys_r[j] == keys_i[i]) begin
          seen = 1'b1;
        end
      end
      new_mask[i] = (i < KEY_SLOTS) && (keys_i[i] != 8'h00) && !seen;
    end
  end

  always_comb begin
    cmd_o.kind      = action_i ? hrps2_pkg::CMD_TABLE_WR : hrps2_pkg::CMD_REPORT;
    cmd_o.shift_ev  = hrps2_pkg::SH_NONE;
    if (shift && !prev_shift_r) begin
      cmd_o.shift_ev = hrps2_pkg::SH_MAKE;
    end else if (!shift && prev_shift_r) begin
      cmd_o.shift_ev = hrps2_pkg::SH_BREAK;
    end
    cmd_o.new_mask  = new_mask;
    cmd_o.keys      = keys_i;
    cmd_o.tbl_index = table_index_i;
    cmd_o.tbl_code  = table_code_i;
  end

  // history only moves on keyboard reports
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_shift_r <= 1'b0;
      for (int i = 0; i < hrps2_pkg::MAX_SLOTS; i++) begin
        prev_keys_r[i] <= 8'h00;
      end
    end else if (accept_i && !action_i) begin
      prev_shift_r <= shift;
      for (int i = 0; i < hrps2_pkg::MAX_SLOTS; i++) begin
        prev_keys_r[i] <= keys_i[i];
      end
    end
  end

endmodule

@@ rtl/hrps2_back.sv @@
`timescale 1ns / 1ps

module hrps2_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hrps2_pkg::cmd_t        cmd_i,
  input  logic                   cmd_empty_i,
  output logic                   cmd_pop_o,
  input  logic                   out_pop_i,
  output logic                   out_push_o,
  output hrps2_pkg::out_item_t   out_item_o
);

  localparam int OUT_CNT_W = $clog2(hrps2_pkg::OUT_DEPTH + 1);

  // request being worked off
  logic                              cur_valid_r;
  hrps2_pkg::cmd_kind_t              cur_kind_r;
  hrps2_pkg::shift_ev_t              cur_shift_r;
  hrps2_pkg::shift_ev_t              cur_shift_nxt;
  logic [hrps2_pkg::MAX_SLOTS-1:0]   cur_mask_r;
  logic [hrps2_pkg::MAX_SLOTS-1:0]   cur_mask_nxt;
  logic [hrps2_pkg::MAX_SLOTS-1:0][7:0] cur_keys_r;
  hrps2_pkg::byte_t                  cur_idx_r;
  hrps2_pkg::byte_t                  cur_code_r;

  // translation table
  hrps2_pkg::byte_t                  tbl_mem [256];
  hrps2_pkg::byte_t                  tbl_q_r;
  logic                              tbl_we;
  hrps2_pkg::byte_t                  rd_addr;

  // issue stage, registered in front of the output queue
  logic                              iss_valid_r;
  logic                              iss_tbl_r;
  hrps2_pkg::byte_t                  iss_lit_r;
  logic                              iss_last_r;

  logic [OUT_CNT_W-1:0]              outstanding_r;
  logic                              credit;

  logic                              emit;
  logic                              emit_tbl;
  hrps2_pkg::byte_t                  emit_lit;
  logic                              emit_last;
  logic                              done;
  logic                              load;
  logic [hrps2_pkg::SLOT_W-1:0]      sel;
  logic [hrps2_pkg::MAX_SLOTS-1:0]   mask_rest;

  assign credit    = (outstanding_r < OUT_CNT_W'(hrps2_pkg::OUT_DEPTH));
  assign mask_rest = cur_mask_r & (cur_mask_r - hrps2_pkg::MAX_SLOTS'(1));
  assign rd_addr   = cur_keys_r[sel];

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = hrps2_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
      if (cur_mask_r[i]) begin
        sel = hrps2_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    emit          = 1'b0;
    emit_tbl      = 1'b0;
    emit_lit      = hrps2_pkg::SHIFT_MAKE;
    emit_last     = 1'b0;
    done          = 1'b0;
    tbl_we        = 1'b0;
    cur_shift_nxt = cur_shift_r;
    cur_mask_nxt  = cur_mask_r;
    if (cur_valid_r) begin
      if (cur_kind_r == hrps2_pkg::CMD_TABLE_WR) begin
        tbl_we = 1'b1;
        done   = 1'b1;
      end else begin
        unique case (cur_shift_r)
          hrps2_pkg::SH_BREAK: begin
            if (credit) begin
              emit          = 1'b1;
              emit_lit      = hrps2_pkg::BREAK_PREFIX;
              cur_shift_nxt = hrps2_pkg::SH_MAKE;
            end
          end
          hrps2_pkg::SH_MAKE: begin
            if (credit) begin
              emit          = 1'b1;
              emit_lit      = hrps2_pkg::SHIFT_MAKE;
              emit_last     = (cur_mask_r == '0);
              done          = (cur_mask_r == '0);
              cur_shift_nxt = hrps2_pkg::SH_NONE;
            end
          end
          default: begin
            // no shift byte pending: new keys
            if (cur_mask_r == '0) begin
              done = 1'b1;
            end else if (credit) begin
              emit         = 1'b1;
              emit_tbl     = 1'b1;
              emit_last    = (mask_rest == '0);
              done         = (mask_rest == '0);
              cur_mask_nxt = mask_rest;
            end
          end
        endcase
      end
    end
  end

  assign load      = !cur_valid_r || done;
  assign cmd_pop_o = load && !cmd_empty_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_shift_r <= hrps2_pkg::SH_NONE;
      cur_mask_r  <= '0;
    end else if (load) begin
      cur_valid_r <= !cmd_empty_i;
      cur_shift_r <= cmd_i.shift_ev;
      cur_mask_r  <= cmd_i.new_mask;
    end else begin
      cur_shift_r <= cur_shift_nxt;
      cur_mask_r  <= cur_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_kind_r <= cmd_i.kind;
      cur_keys_r <= cmd_i.keys;
      cur_idx_r  <= cmd_i.tbl_index;
      cur_code_r <= cmd_i.tbl_code;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[cur_idx_r] <= cur_code_r;
    end
    tbl_q_r <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_valid_r <= 1'b0;
    end else begin
      iss_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    iss_tbl_r  <= emit_tbl;
    iss_lit_r  <= emit_lit;
    iss_last_r <= emit_last;
  end

  // bytes in flight or queued; issue stops when the output queue could overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      case ({emit, out_pop_i})
        2'b10:   outstanding_r <= outstanding_r + OUT_CNT_W'(1);
        2'b01:   outstanding_r <= outstanding_r - OUT_CNT_W'(1);
        default: outstanding_r <= outstanding_r;
      endcase
    end
  end

  assign out_push_o           = iss_valid_r;
  assign out_item_o.scan_byte = iss_tbl_r ? tbl_q_r : iss_lit_r;
  assign out_item_o.last      = iss_last_r;

endmodule

@@ rtl/hid_report_to_ps2_make_codes.sv @@
`timescale 1ns / 1ps
// USB boot-keyboard report to PS/2 set-2 make-code translator. Push a request
// with in_action = 0 to deliver a keyboard report or in_action = 1 to write one
// entry of the 256-entry translation table (in_table_index, in_table_code);
// table writes produce no output and must precede any report that looks up
// that entry, since unwritten entries read back as garbage. For each report
// the block emits 0x12 when shift goes down, 0xF0 0x12 when it comes up, then
// the table byte of every new nonzero key in slot order; out_last marks the
// final byte of a report, and a report that yields no bytes yields nothing.
// Throughput: the back end sends one byte per cycle while the output queue has
// room, and a report yields at most 8 bytes; the single table read port sets
// that pace. The front end takes a request every cycle while the 2-deep request
// queue has room. With the back end idle, the first byte of a report passes
// through the request queue, the back end's current-request register, the
// issue stage and the output queue before it can be popped.

`include "hid_report_to_ps2_make_codes_defines.svh"

module hid_report_to_ps2_make_codes #(
  parameter int KEY_SLOTS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  // request side
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_action,
  input  logic [7:0] in_modifier,
  input  logic [7:0] in_key0,
  input  logic [7:0] in_key1,
  input  logic [7:0] in_key2,
  input  logic [7:0] in_key3,
  input  logic [7:0] in_key4,
  input  logic [7:0] in_key5,
  input  logic [7:0] in_table_index,
  input  logic [7:0] in_table_code,
  // result side
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_scan_byte,
  output logic       out_last
);

  localparam int CMD_W = $bits(hrps2_pkg::cmd_t);
  localparam int OUT_W = $bits(hrps2_pkg::out_item_t);

  logic                                  in_accept;
  logic [hrps2_pkg::MAX_SLOTS-1:0][7:0]  keys;
  hrps2_pkg::cmd_t                       cmd_new;
  hrps2_pkg::cmd_t                       cmd_head;
  logic [CMD_W-1:0]                      cmd_rd_bits;
  logic                                  cmd_empty;
  logic                                  cmd_pop;
  logic                                  out_push;
  logic                                  out_full;
  logic                                  out_accept;
  hrps2_pkg::out_item_t                  out_item;
  hrps2_pkg::out_item_t                  out_head;
  logic [OUT_W-1:0]                      out_rd_bits;

  assign in_accept  = in_push && !in_full;
  assign out_accept = out_pop && !out_empty;
  assign keys       = {in_key5, in_key4, in_key3, in_key2, in_key1, in_key0};

  // front end: compares against the last report and classifies the request
  hrps2_front #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept_i      (in_accept),
    .action_i      (in_action),
    .modifier_i    (in_modifier),
    .keys_i        (keys),
    .table_index_i (in_table_index),
    .table_code_i  (in_table_code),
    .cmd_o         (cmd_new)
  );

  // request queue decoupling front and back
  hrps2_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (hrps2_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (cmd_new),
    .full    (in_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd_bits),
    .empty   (cmd_empty)
  );

  assign cmd_head = hrps2_pkg::cmd_t'(cmd_rd_bits);

  // back end: owns the translation table and sequences the output bytes
  hrps2_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_pop_i   (out_accept),
    .out_push_o  (out_push),
    .out_item_o  (out_item)
  );

  // output queue; the back end only issues against free space here
  hrps2_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (hrps2_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_push),
    .wr_data (out_item),
    .full    (out_full),
    .rd_en   (out_pop),
    .rd_data (out_rd_bits),
    .empty   (out_empty)
  );

  assign out_head      = hrps2_pkg::out_item_t'(out_rd_bits);
  assign out_scan_byte = out_head.scan_byte;
  assign out_last      = out_head.last;

  // credit accounting must keep the output queue from overflowing
  `HRPS2_ASSERT_SAME(a_out_no_overflow, out_push, !out_full, "output queue overflow")
  // a request accepted while the request queue is empty lands in that queue
  `HRPS2_ASSERT_NEXT(a_cmd_lands, in_accept && cmd_empty, !cmd_empty, "request lost")
  // nothing appears at the output unless the back end pushed it
  `HRPS2_ASSERT_NEXT(a_no_phantom, out_empty && !out_push, out_empty, "phantom output byte")

endmodule
